@@ src/wmc_pkg.sv @@
`timescale 1ns / 1ps

package wmc_pkg;

	localparam int MAX_PARTICLES = 256;
	localparam int MAX_DIM       = 4;

	localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int PIDX_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int PCNT_W  = PIDX_W + 1;
	localparam int PADDR_W = PIDX_W + DIM_W;

	localparam int PSTORE_DEPTH = MAX_PARTICLES * (1 << DIM_W);
	localparam int WSTORE_DEPTH = MAX_PARTICLES;

	localparam int COMP_W   = 32;
	localparam int WEIGHT_W = 17;
	localparam int VALUE_W  = 64;
	localparam int CFG_W    = 3;
	localparam int IDX_W    = 2;
	localparam int MAG_W    = 66;

	localparam logic [CFG_W-1:0] DIM_RESET = 3'd4;

	typedef logic signed [VALUE_W-1:0] acc_t;

	localparam acc_t ACC_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	function automatic logic [DIM_W:0] eff_dim(input logic [CFG_W-1:0] d);
		logic [DIM_W:0] r;
		if (d == '0) begin
			r = (DIM_W+1)'(1);
		end else if (int'(d) > MAX_DIM) begin
			r = (DIM_W+1)'(MAX_DIM);
		end else begin
			r = (DIM_W+1)'(d);
		end
		return r;
	endfunction

	function automatic acc_t sat_add(input acc_t a, input acc_t b);
		acc_t s;
		s = a + b;
		if (a[VALUE_W-1] == b[VALUE_W-1] && s[VALUE_W-1] != a[VALUE_W-1]) begin
			s = a[VALUE_W-1] ? ACC_MIN : ACC_MAX;
		end
		return s;
	endfunction

	function automatic acc_t sign_mag_sat(input logic neg, input logic [MAG_W-1:0] mag);
		acc_t r;
		if (|mag[MAG_W-1:VALUE_W-1]) begin
			r = neg ? ACC_MIN : ACC_MAX;
		end else begin
			r = neg ? -acc_t'(mag[VALUE_W-1:0]) : acc_t'(mag[VALUE_W-1:0]);
		end
		return r;
	endfunction

endpackage

@@ src/weighted_mean_covariance.sv @@
`timescale 1ns / 1ps
// Channel  | Signals                                          | Handshake
// ---------+--------------------------------------------------+---------------------------
// input    | component, weight, last_item                     | taken when start && !busy
// config   | dim_in_use                                       | written when dim_in_use_we
// result   | value, is_covariance, row, col, overflow, last   | one cycle, result_valid
//
// Loading accepts one item per cycle while idle. After the item marked last the block
// stays busy through the mean and covariance passes, paced by one shared 32x32
// multiplier and a single read of the particle memory per step.
// Results leave at the mean and covariance finish steps; the receiver cannot stall them.
// Reset clears the sequencer, counts and overflow flag; dim_in_use resets to 4.

module weighted_mean_covariance (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [wmc_pkg::COMP_W-1:0]   component,
	input  logic [wmc_pkg::WEIGHT_W-1:0]        weight,
	input  logic                                last_item,
	input  logic                                dim_in_use_we,
	input  logic [wmc_pkg::CFG_W-1:0]           dim_in_use,
	output logic                                result_valid,
	output logic signed [wmc_pkg::VALUE_W-1:0]  value,
	output logic                                is_covariance,
	output logic [wmc_pkg::IDX_W-1:0]           row,
	output logic [wmc_pkg::IDX_W-1:0]           col,
	output logic                                overflow,
	output logic                                last
);

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_MRD  = 17'h00002,
		S_MABS = 17'h00004,
		S_MMUL = 17'h00008,
		S_MRND = 17'h00010,
		S_MFIN = 17'h00020,
		S_CRDJ = 17'h00040,
		S_CRDK = 17'h00080,
		S_CDK  = 17'h00100,
		S_CABS = 17'h00200,
		S_CM1  = 17'h00400,
		S_CM2  = 17'h00800,
		S_CM3  = 17'h01000,
		S_CSUM = 17'h02000,
		S_TERM = 17'h04000,
		S_ACC  = 17'h08000,
		S_CFIN = 17'h10000
	} state_t;

	localparam int DIM_W  = wmc_pkg::DIM_W;
	localparam int PIDX_W = wmc_pkg::PIDX_W;
	localparam int PCNT_W = wmc_pkg::PCNT_W;

	state_t                          state_q;
	logic [wmc_pkg::CFG_W-1:0]       dim_q;
	logic [PCNT_W-1:0]               pc_q;
	logic [DIM_W-1:0]                cc_q;
	logic                            ovf_q;
	logic [PIDX_W-1:0]               p_q;
	logic [DIM_W-1:0]                j_q;
	logic [DIM_W-1:0]                k_q;
	logic                            cov_q;
	logic                            valid_q;
	logic                            last_q;

	wmc_pkg::acc_t                   acc_q;
	wmc_pkg::acc_t                   term_q;
	logic [wmc_pkg::MAG_W-1:0]       mag_q;
	logic [32:0]                     lo_q;
	logic [31:0]                     phi_q;
	logic [63:0]                     mul_q;
	logic [31:0]                     da_q;
	logic [31:0]                     db_q;
	logic signed [32:0]              dj_q;
	logic signed [32:0]              dk_q;
	logic [wmc_pkg::WEIGHT_W-1:0]    w_q;
	logic                            neg_q;
	logic [47:0]                     rnd_q;
	logic signed [31:0]              mean_q [wmc_pkg::MAX_DIM];

	wmc_pkg::acc_t                   value_q;
	logic                            is_cov_q;
	logic [wmc_pkg::IDX_W-1:0]       row_q;
	logic [wmc_pkg::IDX_W-1:0]       col_q;
	logic                            ovf_out_q;

	logic [DIM_W:0]                  dim_eff;
	logic                            accept;
	logic                            store_ok;
	logic [DIM_W:0]                  cc_inc;
	logic                            wrap;
	logic [PCNT_W-1:0]               pc_nx;
	logic [DIM_W-1:0]                cc_nx;
	logic [DIM_W:0]                  j_inc;
	logic [DIM_W:0]                  k_inc;
	logic [PIDX_W:0]                 p_inc;
	logic                            j_last;
	logic                            k_last;
	logic                            p_last;
	logic                            no_particles;

	logic [wmc_pkg::PADDR_W-1:0]     prd_addr;
	logic [wmc_pkg::COMP_W-1:0]      prd;
	logic [wmc_pkg::WEIGHT_W-1:0]    wrd;

	logic [31:0]                     mul_a;
	logic [31:0]                     mul_b;
	logic [63:0]                     mul_p;
	logic                            mul_en;

	logic signed [31:0]              mean_sel;
	logic signed [31:0]              mean_nx;
	logic [63:0]                     rnd_sum;
	logic [49:0]                     lo_rnd;
	logic [32:0]                     dj_neg;
	logic [32:0]                     dk_neg;
	logic [31:0]                     x_neg;

	assign dim_eff  = wmc_pkg::eff_dim(dim_q);
	assign accept   = start && (state_q == S_IDLE);
	assign store_ok = pc_q < PCNT_W'(wmc_pkg::MAX_PARTICLES);
	assign cc_inc   = {1'b0, cc_q} + 1'b1;
	assign wrap     = cc_inc >= dim_eff;
	assign pc_nx    = (wrap && store_ok) ? pc_q + 1'b1 : pc_q;
	assign cc_nx    = wrap ? '0 : cc_inc[DIM_W-1:0];

	assign j_inc        = {1'b0, j_q} + 1'b1;
	assign k_inc        = {1'b0, k_q} + 1'b1;
	assign p_inc        = {1'b0, p_q} + 1'b1;
	assign j_last       = j_inc >= dim_eff;
	assign k_last       = k_inc >= dim_eff;
	assign p_last       = p_inc >= pc_q;
	assign no_particles = (pc_q == '0);

	assign prd_addr = {p_q, (state_q == S_CRDK) ? k_q : j_q};

	wmc_ram #(
		.WIDTH (wmc_pkg::COMP_W),
		.DEPTH (wmc_pkg::PSTORE_DEPTH)
	) u_particle_ram (
		.clk   (clk),
		.we    (accept && store_ok),
		.waddr ({pc_q[PIDX_W-1:0], cc_q}),
		.wdata (component),
		.raddr (prd_addr),
		.rdata (prd)
	);

	wmc_ram #(
		.WIDTH (wmc_pkg::WEIGHT_W),
		.DEPTH (wmc_pkg::WSTORE_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (accept && store_ok && (cc_q == '0)),
		.waddr (pc_q[PIDX_W-1:0]),
		.wdata (weight),
		.raddr (p_q),
		.rdata (wrd)
	);

	always_comb begin
		mul_en = 1'b1;
		case (state_q)
			S_MMUL: begin
				mul_a = da_q;
				mul_b = 32'(w_q);
			end
			S_CM1: begin
				mul_a = da_q;
				mul_b = db_q;
			end
			S_CM2: begin
				mul_a = mul_q[31:0];
				mul_b = 32'(w_q);
			end
			S_CM3: begin
				mul_a = phi_q;
				mul_b = 32'(w_q);
			end
			default: begin
				mul_a  = da_q;
				mul_b  = db_q;
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign mean_sel = mean_q[(state_q == S_CDK) ? k_q : j_q];
	assign rnd_sum  = acc_q[63] ? (~acc_q + 64'h8001) : (acc_q + 64'h8000);
	assign lo_rnd   = {1'b0, mul_q[48:0]} + 50'h8000;
	assign dj_neg   = -dj_q;
	assign dk_neg   = -dk_q;
	assign x_neg    = -prd;

	always_comb begin
		if (|rnd_q[47:31]) begin
			mean_nx = acc_q[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		end else begin
			mean_nx = acc_q[63] ? -rnd_q[31:0] : rnd_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dim_q   <= wmc_pkg::DIM_RESET;
			pc_q    <= '0;
			cc_q    <= '0;
			ovf_q   <= 1'b0;
			p_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			cov_q   <= 1'b0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			if (dim_in_use_we) begin
				dim_q <= dim_in_use;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pc_q <= pc_nx;
						cc_q <= cc_nx;
						if (!store_ok) begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							p_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
							cov_q   <= 1'b0;
							state_q <= (pc_nx == '0) ? S_MRND : S_MRD;
						end
					end
				end
				S_MRD:  state_q <= S_MABS;
				S_MABS: state_q <= S_MMUL;
				S_MMUL: state_q <= S_TERM;
				S_TERM: state_q <= S_ACC;
				S_ACC: begin
					if (!p_last) begin
						p_q     <= p_inc[PIDX_W-1:0];
						state_q <= cov_q ? S_CRDJ : S_MRD;
					end else begin
						p_q     <= '0;
						state_q <= cov_q ? S_CFIN : S_MRND;
					end
				end
				S_MRND: state_q <= S_MFIN;
				S_MFIN: begin
					valid_q <= 1'b1;
					if (!j_last) begin
						j_q     <= j_inc[DIM_W-1:0];
						state_q <= no_particles ? S_MRND : S_MRD;
					end else begin
						j_q     <= '0;
						k_q     <= '0;
						cov_q   <= 1'b1;
						state_q <= no_particles ? S_CFIN : S_CRDJ;
					end
				end
				S_CRDJ: state_q <= S_CRDK;
				S_CRDK: state_q <= S_CDK;
				S_CDK:  state_q <= S_CABS;
				S_CABS: state_q <= S_CM1;
				S_CM1:  state_q <= S_CM2;
				S_CM2:  state_q <= S_CM3;
				S_CM3:  state_q <= S_CSUM;
				S_CSUM: state_q <= S_TERM;
				S_CFIN: begin
					valid_q <= 1'b1;
					if (!k_last) begin
						k_q     <= k_inc[DIM_W-1:0];
						state_q <= no_particles ? S_CFIN : S_CRDJ;
					end else if (!j_last) begin
						j_q     <= j_inc[DIM_W-1:0];
						k_q     <= '0;
						state_q <= no_particles ? S_CFIN : S_CRDJ;
					end else begin
						last_q  <= 1'b1;
						j_q     <= '0;
						k_q     <= '0;
						cov_q   <= 1'b0;
						pc_q    <= '0;
						cc_q    <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= mul_p;
		end
		case (state_q)
			S_IDLE: begin
				if (accept && last_item) begin
					acc_q <= '0;
				end
			end
			S_MABS: begin
				da_q  <= prd[31] ? x_neg : prd;
				w_q   <= wrd;
				neg_q <= prd[31];
			end
			S_CRDK: begin
				dj_q <= {prd[31], prd} - {mean_sel[31], mean_sel};
				w_q  <= wrd;
			end
			S_CDK: begin
				dk_q <= {prd[31], prd} - {mean_sel[31], mean_sel};
			end
			S_CABS: begin
				da_q  <= dj_q[32] ? dj_neg[31:0] : dj_q[31:0];
				db_q  <= dk_q[32] ? dk_neg[31:0] : dk_q[31:0];
				neg_q <= dj_q[32] ^ dk_q[32];
			end
			S_CM2: phi_q <= mul_q[63:32];
			S_CM3: lo_q  <= lo_rnd[48:16];
			S_CSUM: mag_q <= {1'b0, mul_q[48:0], 16'b0} + {33'b0, lo_q};
			S_TERM: term_q <= wmc_pkg::sign_mag_sat(neg_q, cov_q ? mag_q : {2'b0, mul_q});
			S_ACC:  acc_q  <= wmc_pkg::sat_add(acc_q, term_q);
			S_MRND: rnd_q  <= rnd_sum[63:16];
			S_MFIN: begin
				mean_q[j_q] <= mean_nx;
				value_q     <= {{32{mean_nx[31]}}, mean_nx};
				is_cov_q    <= 1'b0;
				row_q       <= wmc_pkg::IDX_W'(j_q);
				col_q       <= '0;
				ovf_out_q   <= ovf_q;
				acc_q       <= '0;
			end
			S_CFIN: begin
				value_q   <= acc_q;
				is_cov_q  <= 1'b1;
				row_q     <= wmc_pkg::IDX_W'(j_q);
				col_q     <= wmc_pkg::IDX_W'(k_q);
				ovf_out_q <= ovf_q;
				acc_q     <= '0;
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign result_valid  = valid_q;
	assign value         = value_q;
	assign is_covariance = is_cov_q;
	assign row           = row_q;
	assign col           = col_q;
	assign overflow      = ovf_out_q;
	assign last          = last_q;

endmodule

@@ src/wmc_ram.sv @@
`timescale 1ns / 1ps

module wmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/wmc_checker.sv @@
`timescale 1ns / 1ps

module wmc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_item,
	input logic result_valid,
	input logic last
);

	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("result before the end of the run while idle");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> result_valid)
		else $error("last flag without a result");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result after the final result of the run");

	a_last_item_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_item |=> busy)
		else $error("last item did not start the computation");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_item |=> !busy)
		else $error("block went busy on a plain load item");

endmodule

bind weighted_mean_covariance wmc_checker u_wmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_item    (last_item),
	.result_valid (result_valid),
	.last         (last)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic [63:0] val;
		logic        is_cov;
		logic [1:0]  row_i;
		logic [1:0]  col_i;
		logic        ovf;
		logic        fin;
	} moment_t;

	localparam logic signed [127:0] S64_MAX  = 128'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [127:0] S64_MIN  = -128'sh8000_0000_0000_0000;
	localparam logic signed [127:0] S32_MAX  = 128'sh7FFF_FFFF;
	localparam logic signed [127:0] S32_MIN  = -128'sh8000_0000;
	localparam logic signed [127:0] HALF_LSB = 128'sh8000;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic signed [wmc_pkg::COMP_W-1:0]   component = '0;
	logic [wmc_pkg::WEIGHT_W-1:0]        weight = '0;
	logic                                last_item = 1'b0;
	logic                                dim_in_use_we = 1'b0;
	logic [wmc_pkg::CFG_W-1:0]           dim_in_use = wmc_pkg::DIM_RESET;
	logic                                result_valid;
	logic signed [wmc_pkg::VALUE_W-1:0]  value;
	logic                                is_covariance;
	logic [wmc_pkg::IDX_W-1:0]           row;
	logic [wmc_pkg::IDX_W-1:0]           col;
	logic                                overflow;
	logic                                last;

	logic signed [wmc_pkg::COMP_W-1:0]   part_mem [wmc_pkg::MAX_PARTICLES][wmc_pkg::MAX_DIM];
	logic [wmc_pkg::WEIGHT_W-1:0]        wt_mem [wmc_pkg::MAX_PARTICLES];
	int unsigned                         part_cnt = 0;
	int unsigned                         comp_cnt = 0;
	logic                                ovf_seen = 1'b0;
	logic [wmc_pkg::CFG_W-1:0]           dim_reg = wmc_pkg::DIM_RESET;
	moment_t                             moments_due [$];
	int                                  mismatch_count = 0;
	bit                                  idle_on = 1'b1;

	weighted_mean_covariance dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.component     (component),
		.weight        (weight),
		.last_item     (last_item),
		.dim_in_use_we (dim_in_use_we),
		.dim_in_use    (dim_in_use),
		.result_valid  (result_valid),
		.value         (value),
		.is_covariance (is_covariance),
		.row           (row),
		.col           (col),
		.overflow      (overflow),
		.last          (last)
	);

	always #2 clk = ~clk;

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic signed [127:0] clamp(input logic signed [127:0] v,
			input logic signed [127:0] lo, input logic signed [127:0] hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic int unsigned dims_of(input logic [wmc_pkg::CFG_W-1:0] d);
		if (d == '0) return 1;
		if (d > wmc_pkg::MAX_DIM) return wmc_pkg::MAX_DIM;
		return 32'(d);
	endfunction

	function automatic logic signed [wmc_pkg::COMP_W-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
		endcase
	endfunction

	function automatic logic [wmc_pkg::WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return wmc_pkg::WEIGHT_W'($urandom_range(0, 17'h1FFFF));
			1: return 17'h10000;
			default: return wmc_pkg::WEIGHT_W'($urandom_range(0, 17'h10000));
		endcase
	endfunction

	task automatic fold_component(input logic signed [wmc_pkg::COMP_W-1:0] comp,
			input logic [wmc_pkg::WEIGHT_W-1:0] w, input logic fin);
		int unsigned d, p, j, k;
		logic signed [127:0] mean_acc [wmc_pkg::MAX_DIM];
		logic signed [127:0] cov_acc [wmc_pkg::MAX_DIM][wmc_pkg::MAX_DIM];
		logic signed [31:0] mu [wmc_pkg::MAX_DIM];
		logic signed [127:0] da, db, ma, wide_w, mag, term;
		logic signed [63:0] v64;
		logic neg;
		moment_t m;
		d = dims_of(dim_reg);
		if (comp_cnt >= wmc_pkg::MAX_DIM) comp_cnt = 0;
		if (part_cnt < wmc_pkg::MAX_PARTICLES) begin
			if (comp_cnt == 0) wt_mem[part_cnt] = w;
			part_mem[part_cnt][comp_cnt] = comp;
		end else begin
			ovf_seen = 1'b1;
		end
		comp_cnt++;
		if (comp_cnt >= d) begin
			comp_cnt = 0;
			if (part_cnt < wmc_pkg::MAX_PARTICLES) part_cnt++;
		end
		if (!fin) return;

		for (j = 0; j < d; j++) begin
			mean_acc[j] = '0;
			for (k = 0; k < d; k++) cov_acc[j][k] = '0;
		end
		for (p = 0; p < part_cnt; p++) begin
			wide_w = 128'({1'b0, wt_mem[p]});
			for (j = 0; j < d; j++) begin
				da = 128'(part_mem[p][j]);
				mean_acc[j] = clamp(mean_acc[j] + da * wide_w, S64_MIN, S64_MAX);
			end
		end
		for (j = 0; j < d; j++) begin
			mag = (mean_acc[j] < 0) ? -mean_acc[j] : mean_acc[j];
			mag = (mag + HALF_LSB) >>> 16;
			term = clamp((mean_acc[j] < 0) ? -mag : mag, S32_MIN, S32_MAX);
			mu[j] = term[31:0];
		end
		for (p = 0; p < part_cnt; p++) begin
			wide_w = 128'({1'b0, wt_mem[p]});
			for (j = 0; j < d; j++) begin
				for (k = 0; k < d; k++) begin
					da = 128'(part_mem[p][j]);
					ma = 128'(mu[j]);
					da = da - ma;
					db = 128'(part_mem[p][k]);
					ma = 128'(mu[k]);
					db = db - ma;
					neg = (da < 0) != (db < 0);
					mag = ((da < 0) ? -da : da) * ((db < 0) ? -db : db) * wide_w;
					mag = (mag + HALF_LSB) >>> 16;
					term = clamp(neg ? -mag : mag, S64_MIN, S64_MAX);
					cov_acc[j][k] = clamp(cov_acc[j][k] + term, S64_MIN, S64_MAX);
				end
			end
		end

		for (j = 0; j < d; j++) begin
			m = '0;
			v64 = 64'(mu[j]);
			m.val = v64;
			m.row_i = j[1:0];
			m.ovf = ovf_seen;
			moments_due.push_back(m);
		end
		for (j = 0; j < d; j++) begin
			for (k = 0; k < d; k++) begin
				m = '0;
				m.val = cov_acc[j][k][63:0];
				m.is_cov = 1'b1;
				m.row_i = j[1:0];
				m.col_i = k[1:0];
				m.ovf = ovf_seen;
				m.fin = (j == d - 1) && (k == d - 1);
				moments_due.push_back(m);
			end
		end
		part_cnt = 0;
		comp_cnt = 0;
		ovf_seen = 1'b0;
	endtask

	always @(posedge clk) begin
		moment_t want, got;
		if (arst_n && result_valid) begin
			got = {value, is_covariance, row, col, overflow, last};
			if (moments_due.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: value %0d cov %0b row %0d col %0d ovf %0b last %0b",
						value, is_covariance, row, col, overflow, last);
				mismatch_count++;
			end else begin
				want = moments_due.pop_front();
				if (got !== want) begin
					if (mismatch_count < 10) begin
						$display("mismatch: expected value %0d cov %0b row %0d col %0d ovf %0b last %0b",
							$signed(want.val), want.is_cov, want.row_i, want.col_i, want.ovf,
							want.fin);
						$display("          actual   value %0d cov %0b row %0d col %0d ovf %0b last %0b",
							value, is_covariance, row, col, overflow, last);
					end
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_item(input logic signed [wmc_pkg::COMP_W-1:0] comp,
			input logic [wmc_pkg::WEIGHT_W-1:0] w, input logic fin);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		component <= comp;
		weight <= w;
		last_item <= fin;
		do @(posedge clk); while (busy);
		fold_component(comp, w, fin);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (moments_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_dim(input logic [wmc_pkg::CFG_W-1:0] d);
		dim_in_use_we <= 1'b1;
		dim_in_use <= d;
		@(posedge clk);
		dim_in_use_we <= 1'b0;
		dim_reg = d;
	endtask

	task automatic test_default_dim();
		send_item(32'sh7FFF_FFFF, 17'h10000, 1'b0);
		send_item(32'sh8000_0000, rand_weight(), 1'b0);
		send_item(32'sh0000_0000, rand_weight(), 1'b0);
		send_item(32'shFFFF_FFFF, rand_weight(), 1'b0);
		send_item(32'sh8000_0000, 17'h1FFFF, 1'b0);
		send_item(32'sh7FFF_FFFF, 17'h00000, 1'b0);
		send_item(32'sh0001_0000, rand_weight(), 1'b0);
		send_item(32'shFFFF_0000, rand_weight(), 1'b1);
	endtask

	task automatic test_empty_and_partial();
		wait_idle();
		load_dim(wmc_pkg::CFG_W'(3));
		send_item(rand_comp(), rand_weight(), 1'b1);
		send_item(32'sh0002_8000, 17'h08000, 1'b0);
		send_item(-32'sh0001_4000, 17'h08000, 1'b0);
		send_item(32'sh0000_0001, 17'h08000, 1'b0);
		send_item(32'sh1234_5678, 17'h10000, 1'b0);
		send_item(-32'sh0765_4321, 17'h10000, 1'b1);
	endtask

	task automatic test_dim_limits();
		wait_idle();
		load_dim(wmc_pkg::CFG_W'(0));
		send_item(32'sh7FFF_FFFF, 17'h1FFFF, 1'b1);
		send_item(32'sh8000_0000, 17'h1FFFF, 1'b1);
		send_item(32'sh0001_8000, 17'h00000, 1'b0);
		send_item(-32'sh0002_8000, 17'h00001, 1'b0);
		send_item(32'sh1234_5678, 17'h0FFFF, 1'b1);
		wait_idle();
		load_dim(wmc_pkg::CFG_W'(7));
		send_item(rand_comp(), 17'h10000, 1'b0);
		send_item(rand_comp(), rand_weight(), 1'b0);
		send_item(rand_comp(), rand_weight(), 1'b0);
		send_item(rand_comp(), rand_weight(), 1'b1);
	endtask

	task automatic test_store_full();
		int i;
		wait_idle();
		load_dim(wmc_pkg::CFG_W'(1));
		for (i = 0; i < wmc_pkg::MAX_PARTICLES + 4; i++)
			send_item(rand_comp(), rand_weight(), i == wmc_pkg::MAX_PARTICLES + 3);
		send_item(rand_comp(), rand_weight(), 1'b1);
	endtask

	task automatic test_random_sets();
		int unsigned sent, set_no, d, n_part, extra, total, i;
		sent = 0;
		set_no = 0;
		while (sent < 110) begin
			if (set_no % 4 == 0) begin
				wait_idle();
				load_dim(wmc_pkg::CFG_W'($urandom_range(0, 7)));
			end
			idle_on = ($urandom_range(0, 3) != 0);
			d = dims_of(dim_reg);
			n_part = $urandom_range(0, 6);
			extra = ($urandom_range(0, 5) == 0) ? $urandom_range(0, d - 1) : 0;
			total = n_part * d + extra;
			if (total == 0) total = 1;
			for (i = 0; i < total; i++)
				send_item(rand_comp(), rand_weight(), i == total - 1);
			sent += total;
			set_no++;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_dim();
		test_empty_and_partial();
		test_dim_limits();
		test_store_full();
		test_random_sets();
		wait_idle();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && moments_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ weighted_mean_covariance.f @@
src/wmc_pkg.sv
src/wmc_ram.sv
src/weighted_mean_covariance.sv
src/wmc_checker.sv
verif/tb_top.sv
